/* design/cosfm_pkg.sv */
package cosfm_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HI      = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LO      = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
  localparam logic [7:0] START_BYTE  = 8'hFF;
  localparam logic [7:0] HEADER_BYTE = 8'h04;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Link status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DATA  = 3'd1;
  localparam logic [2:0] ST_BAD_FRM  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;

  // Gas level codes
  localparam logic [2:0] LVL_INIT    = 3'd0;
  localparam logic [2:0] LVL_NORMAL  = 3'd1;
  localparam logic [2:0] LVL_WARNING = 3'd2;
  localparam logic [2:0] LVL_ALARM   = 3'd3;
  localparam logic [2:0] LVL_FAULT   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_WARNING = 2'd0;
  localparam logic [1:0] REG_ALARM   = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;
  localparam logic [1:0] REG_SILENCE = 2'd3;

  // Configuration reset values
  localparam logic [8:0]  RST_WARNING = 9'd50;
  localparam logic [8:0]  RST_ALARM   = 9'd100;
  localparam logic [15:0] RST_MAX     = 16'd5000;
  localparam logic [15:0] RST_SILENCE = 16'd5000;

  localparam logic [15:0] QUIET_MAX = 16'hFFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        frame_good;
    logic [2:0]  link_status;
    logic [2:0]  gas_level;
    logic [15:0] reading;
    logic        level_changed;
    logic        fault_raised;
    logic [31:0] good_count;
    logic [31:0] bad_count;
  } out_t;

  // Frame completion event from the framer
  typedef struct packed {
    logic        done;
    logic        hdr_ok;
    logic        sum_ok;
    logic [15:0] value;
  } frame_evt_t;

  // ppm threshold times ten: ppm >= lvl exactly when value >= 10 * lvl
  function automatic logic [12:0] times_ten(input logic [8:0] lvl);
    logic [12:0] w;
    begin
      w = {4'd0, lvl};
      times_ten = (w << 3) + (w << 1);
    end
  endfunction

endpackage

/* design/cosfm_framer.sv */
module cosfm_framer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_en,
  input  logic [7:0]             rx_byte,
  output cosfm_pkg::frame_evt_t  evt
);

  logic                          in_frame_r, in_frame_nxt;
  logic [cosfm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                          hdr_ok_r, hdr_ok_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [7:0]                    hi_r, hi_nxt;
  logic [7:0]                    lo_r, lo_nxt;
  logic [7:0]                    sum_chk;

  // Hunt for the start byte, then keep a running checksum and the reading bytes
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    hdr_ok_nxt   = hdr_ok_r;
    sum_nxt      = sum_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    sum_chk      = sum_r + rx_byte;
    evt.done     = 1'b0;
    evt.hdr_ok   = hdr_ok_r;
    evt.sum_ok   = (sum_chk == 8'd0);
    evt.value    = {hi_r, lo_r};
    if (byte_en) begin
      if (!in_frame_r) begin
        if (rx_byte == cosfm_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = cosfm_pkg::POS_HEADER;
        end
      end else if (pos_r == cosfm_pkg::POS_LAST) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        evt.done     = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == cosfm_pkg::POS_HEADER) begin
          hdr_ok_nxt = (rx_byte == cosfm_pkg::HEADER_BYTE);
          sum_nxt    = rx_byte;
        end else begin
          sum_nxt = sum_chk;
        end
        if (pos_r == cosfm_pkg::POS_HI) hi_nxt = rx_byte;
        if (pos_r == cosfm_pkg::POS_LO) lo_nxt = rx_byte;
      end
    end
  end

  // Hold framing control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_ok_r <= hdr_ok_nxt;
    sum_r    <= sum_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

endmodule

/* design/co_sensor_frame_monitor_unit.sv */
// Result beats are registered in the output register, or in the skid register
// while one result waits. Throughput: one item per cycle while the skid is empty;
// the two-entry output stage (result plus skid register) keeps input accepted.
// Reset: synchronous, active low; clears status to no data, level to init,
// counters and silence timer to zero and thresholds to their defaults.
module co_sensor_frame_monitor_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cosfm_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cosfm_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  logic [8:0]  warn_r, alarm_r;
  logic [15:0] max_r, silence_r;

  logic [2:0]  level_r, level_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] reading_r, reading_nxt;
  logic [15:0] quiet_r, quiet_nxt;
  logic        ever_r, ever_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;

  logic        acc;
  logic        byte_en;
  logic        silent;
  logic [2:0]  cls;
  cosfm_pkg::frame_evt_t evt;
  cosfm_pkg::out_t       res;

  logic            out_v_r;
  logic            skid_v_r;
  cosfm_pkg::out_t out_r;
  cosfm_pkg::out_t skid_r;
  logic            out_take;

  assign acc      = in_valid && !in_stall;
  assign byte_en  = acc && (in_data.kind == cosfm_pkg::KIND_BYTE);
  assign in_stall = skid_v_r;
  assign out_take = out_v_r && !out_stall;

  cosfm_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_data.rx_byte),
    .evt     (evt)
  );

  // Classify a reading against the scaled thresholds
  always_comb begin
    if ({3'd0, evt.value} >= {6'd0, cosfm_pkg::times_ten(alarm_r)}) begin
      cls = cosfm_pkg::LVL_ALARM;
    end else if ({3'd0, evt.value} >= {6'd0, cosfm_pkg::times_ten(warn_r)}) begin
      cls = cosfm_pkg::LVL_WARNING;
    end else begin
      cls = cosfm_pkg::LVL_NORMAL;
    end
  end

  // Update monitor state and build the result beat
  always_comb begin
    level_nxt   = level_r;
    status_nxt  = status_r;
    reading_nxt = reading_r;
    quiet_nxt   = quiet_r;
    ever_nxt    = ever_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    silent      = 1'b0;
    res         = '0;
    if (acc) begin
      if (in_data.kind == cosfm_pkg::KIND_BYTE) begin
        if (evt.done) begin
          if (!evt.hdr_ok) begin
            status_nxt = cosfm_pkg::ST_BAD_FRM;
            bad_nxt    = bad_r + 32'd1;
          end else if (!evt.sum_ok) begin
            status_nxt = cosfm_pkg::ST_BAD_SUM;
            bad_nxt    = bad_r + 32'd1;
          end else if (evt.value > max_r) begin
            status_nxt = cosfm_pkg::ST_INVALID;
            bad_nxt    = bad_r + 32'd1;
          end else begin
            status_nxt        = cosfm_pkg::ST_OK;
            reading_nxt       = evt.value;
            good_nxt          = good_r + 32'd1;
            ever_nxt          = 1'b1;
            quiet_nxt         = '0;
            level_nxt         = cls;
            res.frame_good    = 1'b1;
            res.level_changed = (cls != level_r);
          end
        end
      end else begin
        if (quiet_r != cosfm_pkg::QUIET_MAX) quiet_nxt = quiet_r + 16'd1;
        silent = ever_r ? (quiet_nxt > silence_r) : (quiet_nxt >= silence_r);
        if (silent && (status_r != cosfm_pkg::ST_TIMEOUT)) begin
          status_nxt       = cosfm_pkg::ST_TIMEOUT;
          level_nxt        = cosfm_pkg::LVL_FAULT;
          res.fault_raised = 1'b1;
        end
      end
    end
    res.link_status = status_nxt;
    res.gas_level   = level_nxt;
    res.reading     = reading_nxt;
    res.good_count  = good_nxt;
    res.bad_count   = bad_nxt;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r    <= cosfm_pkg::RST_WARNING;
      alarm_r   <= cosfm_pkg::RST_ALARM;
      max_r     <= cosfm_pkg::RST_MAX;
      silence_r <= cosfm_pkg::RST_SILENCE;
    end else if (cfg_we) begin
      case (cfg_index)
        cosfm_pkg::REG_WARNING: warn_r    <= cfg_wdata[8:0];
        cosfm_pkg::REG_ALARM:   alarm_r   <= cfg_wdata[8:0];
        cosfm_pkg::REG_MAX:     max_r     <= cfg_wdata;
        cosfm_pkg::REG_SILENCE: silence_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= cosfm_pkg::LVL_INIT;
      status_r  <= cosfm_pkg::ST_NO_DATA;
      reading_r <= '0;
      quiet_r   <= '0;
      ever_r    <= 1'b0;
      good_r    <= '0;
      bad_r     <= '0;
    end else begin
      level_r   <= level_nxt;
      status_r  <= status_nxt;
      reading_r <= reading_nxt;
      quiet_r   <= quiet_nxt;
      ever_r    <= ever_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // Output register with skid: drain skid first, otherwise load or park the new beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (acc) begin
      if (!out_v_r || out_take) begin
        out_r   <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a result in the output register");

  a_fault_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.fault_raised) |->
      (out_r.gas_level == cosfm_pkg::LVL_FAULT &&
       out_r.link_status == cosfm_pkg::ST_TIMEOUT))
    else $error("fault raised without timeout status and fault level");

  a_good_clears_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.frame_good) |=> (quiet_r == 16'd0 && ever_r))
    else $error("good reading did not clear the silence timer");
`endif

endmodule
